FILE: rtl/remote_command_frame_parser_macros.svh
// Assertion macros for the remote command frame parser
`ifndef REMOTE_COMMAND_FRAME_PARSER_MACROS_SVH
`define REMOTE_COMMAND_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define RCFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rcfp assertion failed");

// next-cycle implication
`define RCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rcfp assertion failed");

`endif

FILE: rtl/rcfp_pkg.sv
// Shared constants and types for the remote command frame parser
`default_nettype none
package rcfp_pkg;

	localparam int MAX_PACKET_DEF = 256;

	localparam logic [7:0] CH_HEAD = 8'h23;
	localparam logic [7:0] CH_TAIL = 8'h24;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_C    = 8'h43;

	localparam logic [2:0] ST_ALIVE     = 3'd0;
	localparam logic [2:0] ST_REMOTE    = 3'd1;
	localparam logic [2:0] ST_CONTROL   = 3'd2;
	localparam logic [2:0] ST_BAD_HEAD  = 3'd3;
	localparam logic [2:0] ST_UNKNOWN   = 3'd4;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd5;
	localparam logic [2:0] ST_BAD_TAIL  = 3'd6;
	localparam logic [2:0] ST_BAD_PARAM = 3'd7;

	localparam int NUM_PADS = 4;

	typedef struct packed {
		logic [2:0]                 status;
		logic                       alive;
		logic                       remote;
		logic                       restart;
		logic [NUM_PADS-1:0][15:0]  pad;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/rcfp_in_reg.sv
// Input register stage: captures one byte transfer, holds it while blocked
`default_nettype none
module rcfp_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       blocked,
	output logic            byte_stall,
	output logic            valid_s1,
	output logic [7:0]      data_s1,
	output logic            last_s1
);
	assign byte_stall = valid_s1 & blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rcfp_parse.sv
// Parse state, byte capture and end-of-packet status evaluation
`default_nettype none
module rcfp_parse #(
	parameter int MAX_PACKET = rcfp_pkg::MAX_PACKET_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] data_s1,
	input  wire logic       last_s1,
	output rcfp_pkg::result_t res
);
	import rcfp_pkg::*;

	localparam int POS_W = $clog2(MAX_PACKET + 1);

	logic [POS_W-1:0]          pos_q, pos_n;
	logic                      head_q, head_n;
	logic [7:0]                cmd_q, cmd_n;
	logic [7:0]                param_q, param_n;
	logic [7:0]                tail_q, tail_n;
	logic [NUM_PADS-1:0][15:0] stage_q, stage_n;
	logic [NUM_PADS-1:0][15:0] pad_q;
	logic                      remote_q;
	logic                      take;
	logic                      tail_hit;

	always_comb begin
		take    = pos_q < POS_W'(MAX_PACKET);
		pos_n   = take ? pos_q + POS_W'(1) : pos_q;
		head_n  = (take && pos_q == '0) ? (data_s1 == CH_HEAD) : head_q;
		cmd_n   = (take && pos_q == POS_W'(1)) ? data_s1 : cmd_q;
		param_n = (take && pos_q == POS_W'(2)) ? data_s1 : param_q;
		stage_n = stage_q;
		for (int k = 0; k < NUM_PADS; k++) begin
			if (take && pos_q == POS_W'(2 + 2 * k))
				stage_n[k][15:8] = data_s1;
			if (take && pos_q == POS_W'(3 + 2 * k))
				stage_n[k][7:0] = data_s1;
		end
		tail_hit = take && ((cmd_n == CH_A && pos_q == POS_W'(2)) ||
			(cmd_n == CH_R && pos_q == POS_W'(3)) ||
			(cmd_n == CH_C && pos_q == POS_W'(10)));
		tail_n = tail_hit ? data_s1 : tail_q;
	end

	// status and committed values as they stand after this byte
	always_comb begin
		res.status  = ST_UNKNOWN;
		res.alive   = 1'b0;
		res.remote  = remote_q;
		res.restart = 1'b0;
		res.pad     = pad_q;
		if (!head_n) begin
			res.status = ST_BAD_HEAD;
		end else if (pos_n < POS_W'(2)) begin
			res.status = ST_BAD_SIZE;
		end else if (cmd_n == CH_A) begin
			if (pos_n < POS_W'(3)) res.status = ST_BAD_SIZE;
			else if (tail_n != CH_TAIL) res.status = ST_BAD_TAIL;
			else begin
				res.status = ST_ALIVE;
				res.alive  = 1'b1;
			end
		end else if (cmd_n == CH_R) begin
			if (pos_n < POS_W'(4)) res.status = ST_BAD_SIZE;
			else if (tail_n != CH_TAIL) res.status = ST_BAD_TAIL;
			else if (param_n == 8'd0) begin
				res.status  = ST_REMOTE;
				res.remote  = 1'b0;
				res.restart = 1'b1;
			end else if (param_n == 8'd1) begin
				res.status = ST_REMOTE;
				res.remote = 1'b1;
			end else res.status = ST_BAD_PARAM;
		end else if (cmd_n == CH_C) begin
			if (pos_n < POS_W'(11)) res.status = ST_BAD_SIZE;
			else if (tail_n != CH_TAIL) res.status = ST_BAD_TAIL;
			else begin
				res.status = ST_CONTROL;
				res.pad    = stage_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			head_q   <= 1'b0;
			cmd_q    <= '0;
			param_q  <= '0;
			tail_q   <= '0;
			stage_q  <= '0;
			pad_q    <= '0;
			remote_q <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				pos_q    <= '0;
				head_q   <= 1'b0;
				cmd_q    <= '0;
				param_q  <= '0;
				tail_q   <= '0;
				stage_q  <= '0;
				pad_q    <= res.pad;
				remote_q <= res.remote;
			end else begin
				pos_q   <= pos_n;
				head_q  <= head_n;
				cmd_q   <= cmd_n;
				param_q <= param_n;
				tail_q  <= tail_n;
				stage_q <= stage_n;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rcfp_out_reg.sv
// Result register: holds one status transfer until the sink takes it
`default_nettype none
module rcfp_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire rcfp_pkg::result_t res_in,
	input  wire logic          result_stall,
	output logic               result_valid,
	output rcfp_pkg::result_t  res_q
);
	import rcfp_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end
endmodule
`default_nettype wire

FILE: rtl/remote_command_frame_parser.sv
// Top level of the remote command frame parser
// Takes one datagram byte per cycle unless stalled and gives one status transfer
// per byte marked last. The byte side stalls only when a last byte sits
// in the input register while the previous status is still held by a stalled
// sink. Parse state lives in one register set updated by a single pass of
// compare-and-capture logic; committed pad values and the remote flag persist
// across datagrams.
`default_nettype none
`include "remote_command_frame_parser_macros.svh"
module remote_command_frame_parser #(
	parameter int MAX_PACKET = rcfp_pkg::MAX_PACKET_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         byte_valid,
	output logic              byte_stall,
	input  wire logic [7:0]   data_byte,
	input  wire logic         last_byte,
	output logic              result_valid,
	input  wire logic         result_stall,
	output logic [2:0]        status,
	output logic              alive_request,
	output logic              remote_mode,
	output logic              init_restart,
	output logic signed [15:0] pad_axis_0,
	output logic signed [15:0] pad_axis_1,
	output logic signed [15:0] pad_axis_2,
	output logic signed [15:0] pad_axis_3
);
	import rcfp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       blocked;
	logic       fire;
	result_t    res_c;
	result_t    res_q;

	assign blocked = last_s1 & result_valid & result_stall;
	assign fire    = valid_s1 & ~blocked;

	rcfp_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.blocked    (blocked),
		.byte_stall (byte_stall),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.last_s1    (last_s1)
	);

	rcfp_parse #(.MAX_PACKET(MAX_PACKET)) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.data_s1 (data_s1),
		.last_s1 (last_s1),
		.res     (res_c)
	);

	rcfp_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire & last_s1),
		.res_in       (res_c),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.res_q        (res_q)
	);

	assign status        = res_q.status;
	assign alive_request = res_q.alive;
	assign remote_mode   = res_q.remote;
	assign init_restart  = res_q.restart;
	assign pad_axis_0    = $signed(res_q.pad[0]);
	assign pad_axis_1    = $signed(res_q.pad[1]);
	assign pad_axis_2    = $signed(res_q.pad[2]);
	assign pad_axis_3    = $signed(res_q.pad[3]);

	`RCFP_ASSERT_IMPLY(a_stall_cause, clk, arst_n, byte_stall, result_valid && result_stall)
	`RCFP_ASSERT_IMPLY(a_restart_off, clk, arst_n, result_valid && init_restart, !remote_mode && status == ST_REMOTE)
	`RCFP_ASSERT_IMPLY(a_alive_ok, clk, arst_n, result_valid && alive_request, status == ST_ALIVE)
	`RCFP_ASSERT_NEXT(a_last_delivers, clk, arst_n, valid_s1 && last_s1 && !byte_stall, result_valid)
endmodule
`default_nettype wire

FILE: verif/remote_command_frame_parser_tb.sv
// Self-checking testbench for the remote command frame parser: directed and random datagrams
module remote_command_frame_parser_tb;
	import rcfp_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int RST_CYCLES = 12;
	localparam int IDLE_PCT   = 34;
	localparam int RAND_BYTES = 650;
	localparam int DIR_LEN    = 27;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       fix;
		logic [2:0] fst;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        cur_fix = 1'b0;
	logic [2:0]  cur_fst = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  status;
	logic        alive_request;
	logic        remote_mode;
	logic        init_restart;
	logic signed [15:0] pad_axis_0;
	logic signed [15:0] pad_axis_1;
	logic signed [15:0] pad_axis_2;
	logic signed [15:0] pad_axis_3;

	byte_item_t byte_q [$];
	result_t    frame_status_q [$];
	int         total_bytes = 0;
	int         acc_cnt = 0;
	int         err_cnt = 0;
	logic       steady;

	// datagram parse state
	int          frm_pos = 0;
	logic        frm_head_ok = 1'b0;
	logic [7:0]  frm_cmd = '0;
	logic [7:0]  frm_param = '0;
	logic [7:0]  frm_tail = '0;
	logic [15:0] pad_stage [4];
	logic [15:0] pad_hold [4];
	logic        remote_on = 1'b0;

	// status typed in only on the final byte of each datagram
	byte_item_t dir_tbl [DIR_LEN] = '{
		'{CH_HEAD, 1'b1, 1'b1, ST_BAD_SIZE},
		'{8'hFF,   1'b1, 1'b1, ST_BAD_HEAD},
		'{CH_HEAD, 1'b0, 1'b0, ST_ALIVE},
		'{CH_A,    1'b0, 1'b0, ST_ALIVE},
		'{CH_TAIL, 1'b1, 1'b1, ST_ALIVE},
		'{CH_HEAD, 1'b0, 1'b0, ST_ALIVE},
		'{CH_A,    1'b1, 1'b1, ST_BAD_SIZE},
		'{CH_HEAD, 1'b0, 1'b0, ST_ALIVE},
		'{CH_R,    1'b0, 1'b0, ST_ALIVE},
		'{8'h01,   1'b0, 1'b0, ST_ALIVE},
		'{CH_TAIL, 1'b1, 1'b1, ST_REMOTE},
		'{CH_HEAD, 1'b0, 1'b0, ST_ALIVE},
		'{CH_A,    1'b0, 1'b0, ST_ALIVE},
		'{8'h00,   1'b1, 1'b1, ST_BAD_TAIL},
		'{CH_HEAD, 1'b0, 1'b0, ST_ALIVE},
		'{8'h5A,   1'b1, 1'b1, ST_UNKNOWN},
		'{CH_HEAD, 1'b0, 1'b0, ST_ALIVE},
		'{CH_C,    1'b0, 1'b0, ST_ALIVE},
		'{8'h80,   1'b0, 1'b0, ST_ALIVE},
		'{8'h00,   1'b0, 1'b0, ST_ALIVE},
		'{8'h7F,   1'b0, 1'b0, ST_ALIVE},
		'{8'hFF,   1'b0, 1'b0, ST_ALIVE},
		'{8'hFF,   1'b0, 1'b0, ST_ALIVE},
		'{8'hFF,   1'b0, 1'b0, ST_ALIVE},
		'{8'h00,   1'b0, 1'b0, ST_ALIVE},
		'{8'h00,   1'b0, 1'b0, ST_ALIVE},
		'{CH_TAIL, 1'b1, 1'b1, ST_CONTROL}
	};

	remote_command_frame_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.alive_request(alive_request),
		.remote_mode  (remote_mode),
		.init_restart (init_restart),
		.pad_axis_0   (pad_axis_0),
		.pad_axis_1   (pad_axis_1),
		.pad_axis_2   (pad_axis_2),
		.pad_axis_3   (pad_axis_3)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	assign steady = (acc_cnt >= 450) && (acc_cnt < 600);

	task automatic parse_byte(input byte_item_t it);
		result_t r;
		int k;
		if (frm_pos < MAX_PACKET_DEF) begin
			if (frm_pos == 0) begin
				frm_head_ok = (it.data == CH_HEAD);
			end else if (frm_pos == 1) begin
				frm_cmd = it.data;
			end
			if (frm_pos == 2)
				frm_param = it.data;
			if (frm_pos >= 2 && frm_pos <= 9) begin
				k = (frm_pos - 2) >> 1;
				if (frm_pos % 2 == 0)
					pad_stage[k][15:8] = it.data;
				else
					pad_stage[k][7:0] = it.data;
			end
			if ((frm_cmd == CH_A && frm_pos == 2) || (frm_cmd == CH_R && frm_pos == 3) ||
					(frm_cmd == CH_C && frm_pos == 10))
				frm_tail = it.data;
			frm_pos++;
		end
		if (!it.last)
			return;
		r = '0;
		if (!frm_head_ok) begin
			r.status = ST_BAD_HEAD;
		end else if (frm_pos < 2) begin
			r.status = ST_BAD_SIZE;
		end else if (frm_cmd == CH_A) begin
			if (frm_pos < 3) begin
				r.status = ST_BAD_SIZE;
			end else if (frm_tail != CH_TAIL) begin
				r.status = ST_BAD_TAIL;
			end else begin
				r.status = ST_ALIVE;
				r.alive = 1'b1;
			end
		end else if (frm_cmd == CH_R) begin
			if (frm_pos < 4) begin
				r.status = ST_BAD_SIZE;
			end else if (frm_tail != CH_TAIL) begin
				r.status = ST_BAD_TAIL;
			end else if (frm_param == 8'd0) begin
				r.status = ST_REMOTE;
				remote_on = 1'b0;
				r.restart = 1'b1;
			end else if (frm_param == 8'd1) begin
				r.status = ST_REMOTE;
				remote_on = 1'b1;
			end else begin
				r.status = ST_BAD_PARAM;
			end
		end else if (frm_cmd == CH_C) begin
			if (frm_pos < 11) begin
				r.status = ST_BAD_SIZE;
			end else if (frm_tail != CH_TAIL) begin
				r.status = ST_BAD_TAIL;
			end else begin
				r.status = ST_CONTROL;
				for (k = 0; k < NUM_PADS; k++)
					pad_hold[k] = pad_stage[k];
			end
		end else begin
			r.status = ST_UNKNOWN;
		end
		r.remote = remote_on;
		for (k = 0; k < NUM_PADS; k++)
			r.pad[k] = pad_hold[k];
		if (it.fix)
			r.status = it.fst;
		frame_status_q.push_back(r);
		frm_pos = 0;
		frm_head_ok = 1'b0;
		frm_cmd = '0;
		frm_param = '0;
		frm_tail = '0;
		for (k = 0; k < NUM_PADS; k++)
			pad_stage[k] = '0;
	endtask

	task automatic cmp_field(input string fld, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t %s: expected %h, actual %h", $time, fld, want, got);
		end
	endtask

	// well-formed A/R/C datagram with random content, sometimes broken or pure noise
	task automatic gen_frame(input bit overlong, output int len);
		logic [7:0] f [$];
		logic [7:0] b;
		int tail_at;
		int extra;
		int mode;
		int n;
		int i;
		case ($urandom_range(2))
			0: begin
				f.push_back(CH_HEAD);
				f.push_back(CH_A);
				tail_at = 2;
			end
			1: begin
				f.push_back(CH_HEAD);
				f.push_back(CH_R);
				tail_at = 3;
			end
			default: begin
				f.push_back(CH_HEAD);
				f.push_back(CH_C);
				tail_at = 10;
			end
		endcase
		while (f.size() < tail_at)
			f.push_back(8'($urandom_range(255)));
		if (f[1] == CH_R && $urandom_range(9) < 8)
			f[2] = 8'($urandom_range(1));
		f.push_back(CH_TAIL);
		if (overlong)
			extra = $urandom_range(256, 275) - f.size();
		else
			extra = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
		for (i = 0; i < extra; i++)
			f.push_back(8'($urandom_range(255)));
		mode = overlong ? 99 : $urandom_range(99);
		if (mode < 6) begin
			do b = 8'($urandom_range(255)); while (b == CH_HEAD);
			f[0] = b;
		end else if (mode < 12) begin
			f[1] = 8'($urandom_range(255));
		end else if (mode < 18) begin
			n = $urandom_range(1, f.size() - 1);
			while (f.size() > n)
				void'(f.pop_back());
		end else if (mode < 24) begin
			do b = 8'($urandom_range(255)); while (b == CH_TAIL);
			f[tail_at] = b;
		end else if (mode < 28) begin
			n = $urandom_range(1, 12);
			f.delete();
			for (i = 0; i < n; i++)
				f.push_back(8'($urandom_range(255)));
		end
		for (i = 0; i < f.size(); i++)
			byte_q.push_back('{f[i], i == f.size() - 1, 1'b0, ST_ALIVE});
		len = f.size();
	endtask

	// byte source
	always @(posedge clk or negedge arst_n) begin
		byte_item_t it;
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (!byte_valid || !byte_stall) begin
			if (byte_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				it = byte_q.pop_front();
				data_byte <= it.data;
				last_byte <= it.last;
				cur_fix <= it.fix;
				cur_fst <= it.fst;
				byte_valid <= 1'b1;
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// status sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (frame_status_q.size() == 0) begin
				err_cnt++;
				$display("%0t unexpected status transfer: expected none, actual %h", $time, status);
			end else begin
				want = frame_status_q.pop_front();
				cmp_field("status", 16'(want.status), 16'(status));
				cmp_field("alive_request", 16'(want.alive), 16'(alive_request));
				cmp_field("remote_mode", 16'(want.remote), 16'(remote_mode));
				cmp_field("init_restart", 16'(want.restart), 16'(init_restart));
				cmp_field("pad_axis_0", want.pad[0], pad_axis_0);
				cmp_field("pad_axis_1", want.pad[1], pad_axis_1);
				cmp_field("pad_axis_2", want.pad[2], pad_axis_2);
				cmp_field("pad_axis_3", want.pad[3], pad_axis_3);
			end
		end
		if (arst_n && byte_valid && !byte_stall) begin
			parse_byte('{data_byte, last_byte, cur_fix, cur_fst});
			acc_cnt++;
		end
	end

	initial begin
		#(CLK_PERIOD * 200000);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int i;
		int rnd_bytes;
		int len;
		bit long_done;
		for (i = 0; i < NUM_PADS; i++) begin
			pad_stage[i] = '0;
			pad_hold[i] = '0;
		end
		for (i = 0; i < DIR_LEN; i++)
			byte_q.push_back(dir_tbl[i]);
		rnd_bytes = 0;
		long_done = 1'b0;
		while (rnd_bytes < RAND_BYTES) begin
			if (!long_done && rnd_bytes > 300) begin
				gen_frame(1'b1, len);
				long_done = 1'b1;
			end else begin
				gen_frame(1'b0, len);
			end
			rnd_bytes += len;
		end
		total_bytes = byte_q.size();
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		while (acc_cnt < total_bytes || frame_status_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
